// File: sv/assert_macros.svh
// Assertion macros for the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define PPS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define PPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/pps_pkg.sv
// Types, constants and helpers for the priority tick scheduler
`timescale 1ns / 1ps
`default_nettype none

package pps_pkg;

    localparam int MAX_JOBS_DEF = 16;

    localparam int MODE_W = 2;
    localparam int SLOT_W = 4;
    localparam int ARR_W  = 16;
    localparam int PRI_W  = 14;
    localparam int BUR_W  = 16;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_CALC,
        ST_REPORT
    } t_state;

    // One table entry as held in the job memory
    typedef struct packed {
        logic [ARR_W-1:0] arrival;
        logic [PRI_W-1:0] prio;
        logic [BUR_W-1:0] remaining;
        logic [BUR_W-1:0] burst;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Increment time, holding at the top value
    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        return (v == TIME_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: sv/pps_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: sv/preemptive_priority_tick_scheduler.sv
// Preemptive priority tick scheduler: job table in RAM, serial scan per tick
// Load, clear and no-op words: accepted while idle, result strobed the next cycle.
// Tick words: busy through the scan (one RAM read per slot), calc and report states,
// result strobed once back in idle; a new word is taken only when idle again.
// The scan is set by the single read port of the job RAM, one slot per cycle.
// Synchronous active-low reset clears valid bits, time, finish count and job_count.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_tick_scheduler #(
    parameter int MAX_JOBS = pps_pkg::MAX_JOBS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic                      i_cfg_we,
    input  wire logic [pps_pkg::CNT_W-1:0] i_cfg_wdata,
    input  wire logic [pps_pkg::MODE_W-1:0] i_mode,
    input  wire logic [pps_pkg::SLOT_W-1:0] i_slot,
    input  wire logic [pps_pkg::ARR_W-1:0] i_arrival,
    input  wire logic [pps_pkg::PRI_W-1:0] i_priority_req,
    input  wire logic [pps_pkg::BUR_W-1:0] i_burst,
    output logic                           o_strobe,
    output logic                           o_busy_res,
    output logic [pps_pkg::SLOT_W-1:0]     o_ran_slot,
    output logic                           o_finished,
    output logic [pps_pkg::TIME_W-1:0]     o_wait_time,
    output logic [pps_pkg::TIME_W-1:0]     o_turnaround,
    output logic [pps_pkg::TIME_W-1:0]     o_now,
    output logic                           o_all_done
);

    import pps_pkg::*;

    localparam int IDX_W = $clog2(MAX_JOBS);
    localparam int CTR_W = $clog2(MAX_JOBS + 1);

    t_state r_state, n_state;

    logic [MAX_JOBS-1:0] r_valid;
    logic [TIME_W-1:0]   r_now;
    logic [TIME_W-1:0]   r_end;
    logic [CNT_W-1:0]    r_done;
    logic [CNT_W-1:0]    r_job_count;

    logic [CTR_W-1:0]    r_idx;
    logic                r_found;
    logic [IDX_W-1:0]    r_best;
    t_entry              r_best_ent;
    logic                r_fin;
    logic [TIME_W-1:0]   r_tat;

    logic                r_strobe;
    logic                r_busy_res;
    logic [SLOT_W-1:0]   r_ran_slot;
    logic                r_finished;
    logic [TIME_W-1:0]   r_wait_out;
    logic [TIME_W-1:0]   r_tat_out;

    logic                accept;
    logic                load_hit;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [IDX_W+SLOT_W-1:0] best_ext;
    logic [CTR_W-1:0]    idx_m1;
    logic [IDX_W-1:0]    cmp_idx;
    logic                eligible;
    logic                take;
    logic                scan_last;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    t_entry              ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    t_entry              ram_rdata;

    pps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_JOBS)
    ) u_job_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Decode the incoming word
    assign busy      = (r_state != ST_IDLE);
    assign accept    = start && !busy;
    assign slot_ext  = {{IDX_W{1'b0}}, i_slot};
    assign load_hit  = ({{(32 - SLOT_W){1'b0}}, i_slot} < 32'(MAX_JOBS));
    assign best_ext  = {{SLOT_W{1'b0}}, r_best};

    // Scan compare on the entry read in the previous cycle
    assign idx_m1    = r_idx - 1'b1;
    assign cmp_idx   = idx_m1[IDX_W-1:0];
    assign scan_last = (r_idx == CTR_W'(MAX_JOBS));
    assign eligible  = (r_idx != '0) && r_valid[cmp_idx]
                       && ({{(TIME_W - ARR_W){1'b0}}, ram_rdata.arrival} <= r_now)
                       && (ram_rdata.remaining != '0);
    assign take      = eligible && (!r_found || (ram_rdata.prio < r_best_ent.prio));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_mode == MODE_TICK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC:   n_state = ST_REPORT;
            ST_REPORT: n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // RAM port control per state
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_best;
        ram_wdata = r_best_ent;
        ram_raddr = r_idx[IDX_W-1:0];
        case (r_state)
            ST_IDLE: begin
                ram_waddr = slot_ext[IDX_W-1:0];
                ram_wdata = '{arrival: i_arrival, prio: i_priority_req,
                              remaining: i_burst, burst: i_burst};
                ram_we    = accept && (i_mode == MODE_LOAD) && load_hit;
            end
            ST_CALC: begin
                ram_wdata.remaining = r_best_ent.remaining - 1'b1;
                ram_we              = r_found;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_now       <= '0;
            r_done      <= '0;
            r_job_count <= '0;
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            if (i_cfg_we) begin
                r_job_count <= i_cfg_wdata;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        if (i_mode != MODE_TICK) begin
                            r_strobe <= 1'b1;
                        end
                        if ((i_mode == MODE_LOAD) && load_hit) begin
                            r_valid[slot_ext[IDX_W-1:0]] <= 1'b1;
                        end
                        if (i_mode == MODE_CLEAR) begin
                            r_valid <= '0;
                            r_now   <= '0;
                            r_done  <= '0;
                        end
                    end
                end
                ST_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (take) begin
                        r_found <= 1'b1;
                    end
                end
                ST_REPORT: begin
                    r_strobe <= 1'b1;
                    r_now    <= r_end;
                    if (r_fin && (r_done != CNT_MAX)) begin
                        r_done <= r_done + 1'b1;
                    end
                end
                default: begin
                    r_idx <= r_idx;
                end
            endcase
        end
    end

    // Datapath: best candidate, finish times and result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_res <= 1'b0;
            r_ran_slot <= '0;
            r_finished <= 1'b0;
            r_wait_out <= '0;
            r_tat_out  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_end <= sat_inc(r_now);
                    if (accept && (i_mode != MODE_TICK)) begin
                        r_busy_res <= 1'b0;
                        r_ran_slot <= '0;
                        r_finished <= 1'b0;
                        r_wait_out <= '0;
                        r_tat_out  <= '0;
                    end
                end
                ST_SCAN: begin
                    if (take) begin
                        r_best     <= cmp_idx;
                        r_best_ent <= ram_rdata;
                    end
                end
                ST_CALC: begin
                    r_fin <= r_found && (r_best_ent.remaining == BUR_W'(1));
                    r_tat <= r_end - {{(TIME_W - ARR_W){1'b0}}, r_best_ent.arrival};
                end
                ST_REPORT: begin
                    r_busy_res <= r_found;
                    r_ran_slot <= r_found ? best_ext[SLOT_W-1:0] : '0;
                    r_finished <= r_fin;
                    r_tat_out  <= r_fin ? r_tat : '0;
                    if (r_fin && (r_tat >= {{(TIME_W - BUR_W){1'b0}}, r_best_ent.burst})) begin
                        r_wait_out <= r_tat - {{(TIME_W - BUR_W){1'b0}}, r_best_ent.burst};
                    end else begin
                        r_wait_out <= '0;
                    end
                end
                default: begin
                    r_fin <= r_fin;
                end
            endcase
        end
    end

    // Result ports
    assign o_strobe     = r_strobe;
    assign o_busy_res   = r_busy_res;
    assign o_ran_slot   = r_ran_slot;
    assign o_finished   = r_finished;
    assign o_wait_time  = r_wait_out;
    assign o_turnaround = r_tat_out;
    assign o_now        = r_now;
    assign o_all_done   = (r_done == r_job_count);

endmodule

`default_nettype wire

// File: sv/pps_checker.sv
// Port-level checker for the priority tick scheduler, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pps_checker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    input  wire logic                       busy,
    input  wire logic [pps_pkg::MODE_W-1:0] i_mode,
    input  wire logic                       o_strobe,
    input  wire logic                       o_busy_res,
    input  wire logic [pps_pkg::SLOT_W-1:0] o_ran_slot,
    input  wire logic                       o_finished,
    input  wire logic [pps_pkg::TIME_W-1:0] o_wait_time,
    input  wire logic [pps_pkg::TIME_W-1:0] o_turnaround
);

    import pps_pkg::*;

    // A tick word starts a scan, no result in the next cycle
    `PPS_ASSERT_NEXT(a_tick_scans, i_clk, i_rst_n, start && !busy && (i_mode == MODE_TICK), busy && !o_strobe, "tick did not start a scan")

    // Other words answer in the next cycle with no run
    `PPS_ASSERT_NEXT(a_quick_word, i_clk, i_rst_n, start && !busy && (i_mode != MODE_TICK), o_strobe && !o_busy_res, "non-tick word not answered at once")

    // A finished job has run and waited no longer than its turnaround
    `PPS_ASSERT_SAME(a_fin_sane, i_clk, i_rst_n, o_strobe && o_finished, o_busy_res && (o_wait_time <= o_turnaround), "finish result inconsistent")

    // An idle result carries no slot and no times
    `PPS_ASSERT_SAME(a_idle_zero, i_clk, i_rst_n, o_strobe && !o_busy_res, !o_finished && (o_ran_slot == '0) && (o_turnaround == '0), "idle result not cleared")

    // Results appear only once the scan is over
    `PPS_ASSERT_SAME(a_strobe_free, i_clk, i_rst_n, o_strobe, !busy, "result while busy")

endmodule

bind preemptive_priority_tick_scheduler pps_checker u_pps_checker (.*);

`default_nettype wire
